// ----- hw/rtl/gn3_pkg.sv -----
// Shared types and constants of the 3-D gradient noise evaluator.
package gn3_pkg;

  // Permutation table geometry: 256 entries of one byte each.
  localparam int unsigned TBL_AW = 8;
  localparam int unsigned TBL_DW = 8;

  // Input item kinds.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EVAL = 1'b1;

  // Configuration port geometry and register indexes.
  localparam int unsigned CFG_IW = 2;
  localparam int unsigned CFG_DW = 24;
  localparam logic [CFG_IW-1:0] CFG_OFFSET_X = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_OFFSET_Y = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_OFFSET_Z = 2'd2;

  // Coordinate and result formats.
  localparam int unsigned COORD_W = 32;
  localparam int unsigned NOISE_W = 18;
  localparam int unsigned NOISE_FRAC = 16;
  localparam logic signed [NOISE_W-1:0] NOISE_MAX = 18'sd131071;
  localparam logic signed [NOISE_W-1:0] NOISE_MIN = -18'sd131072;

  // Gradient hash lives in the low nibble of a table byte.
  typedef logic [3:0] hash_t;

endpackage

// ----- hw/rtl/gn3_tbl_ram.sv -----
// One copy of the permutation table: one write port, two registered read ports.
module gn3_tbl_ram (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic                           we_i,
  input  logic [gn3_pkg::TBL_AW-1:0]     waddr_i,
  input  logic [gn3_pkg::TBL_DW-1:0]     wdata_i,
  input  logic [gn3_pkg::TBL_AW-1:0]     raddr0_i,
  input  logic [gn3_pkg::TBL_AW-1:0]     raddr1_i,
  output logic [gn3_pkg::TBL_DW-1:0]     rdata0_o,
  output logic [gn3_pkg::TBL_DW-1:0]     rdata1_o
);

  logic [gn3_pkg::TBL_DW-1:0] mem [2**gn3_pkg::TBL_AW];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read ports, held while the pipeline is frozen.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata0_o <= mem[raddr0_i];
      rdata1_o <= mem[raddr1_i];
    end
  end

endmodule

// ----- hw/rtl/gn3_fade.sv -----
// Three-stage quintic fade 6t^5 - 15t^4 + 10t^3 of one fraction.
module gn3_fade #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [FRAC_BITS-1:0] frac_i,
  output logic [FRAC_BITS:0]   fade_o
);

  localparam int unsigned F = FRAC_BITS;
  localparam logic [F+4:0] ONE_P = (F+5)'(1) << F;

  logic [F-1:0]   frac2_q;
  logic [F-1:0]   sq_q;
  logic [F-1:0]   cube_q;
  logic [F+3:0]   poly_q;
  logic [F:0]     fade_q;
  logic [2*F-1:0] sq_full;
  logic [2*F-1:0] cube_full;
  logic [F+4:0]   poly_full;
  logic [2*F+3:0] fade_full;

  // First stage: square.
  assign sq_full = frac_i * frac_i;

  // Second stage: cube and the quadratic factor.
  assign cube_full = sq_q * frac2_q;
  assign poly_full = (F+5)'(6) * (F+5)'(sq_q) + (F+5)'(10) * ONE_P
                     - (F+5)'(15) * (F+5)'(frac2_q);

  // Third stage: final product.
  assign fade_full = cube_q * poly_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q    <= sq_full[2*F-1:F];
      frac2_q <= frac_i;
      cube_q  <= cube_full[2*F-1:F];
      poly_q  <= poly_full[F+3:0];
      fade_q  <= fade_full[2*F:F];
    end
  end

  assign fade_o = fade_q;

endmodule

// ----- hw/rtl/gn3_blend.sv -----
// Gradient dot products, trilinear blend, scaling and the output register.
module gn3_blend #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  gn3_pkg::hash_t         hash_i [8],
  input  logic [FRAC_BITS-1:0]   fx_i,
  input  logic [FRAC_BITS-1:0]   fy_i,
  input  logic [FRAC_BITS-1:0]   fz_i,
  input  logic [FRAC_BITS:0]     u_i,
  input  logic [FRAC_BITS:0]     v_i,
  input  logic [FRAC_BITS:0]     w_i,
  output logic                   valid_o,
  output logic signed [gn3_pkg::NOISE_W-1:0] noise_o
);

  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned DW = F + 4;
  localparam int unsigned PW = (F + 2) + (DW + 1);
  localparam int unsigned SHR = (F >= gn3_pkg::NOISE_FRAC) ? F - gn3_pkg::NOISE_FRAC : 0;
  localparam int unsigned SHL = (F < gn3_pkg::NOISE_FRAC) ? gn3_pkg::NOISE_FRAC - F : 0;
  localparam logic signed [DW-1:0] ONE = DW'(1) << F;

  // Dot product of the hashed gradient with a corner offset.
  function automatic logic signed [DW-1:0] gdot(
    input gn3_pkg::hash_t h,
    input logic signed [DW-1:0] x,
    input logic signed [DW-1:0] y,
    input logic signed [DW-1:0] z
  );
    logic signed [DW-1:0] a;
    logic signed [DW-1:0] b;
    a = (h < 4'd8) ? x : y;
    b = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
    if (h[0]) a = -a;
    if (h[1]) b = -b;
    return a + b;
  endfunction

  // Linear blend a + floor(t * (b - a)).
  function automatic logic signed [DW-1:0] mix(
    input logic [F:0] t,
    input logic signed [DW-1:0] a,
    input logic signed [DW-1:0] b
  );
    logic signed [DW:0]   diff;
    logic signed [PW-1:0] prod;
    diff = (DW+1)'(b) - (DW+1)'(a);
    prod = PW'(signed'({1'b0, t})) * PW'(diff);
    prod = prod >>> F;
    return a + prod[DW-1:0];
  endfunction

  logic signed [DW-1:0] xs [2];
  logic signed [DW-1:0] ys [2];
  logic signed [DW-1:0] zs [2];
  logic signed [DW-1:0] dot5_q [8];
  logic signed [DW-1:0] l6_q [4];
  logic signed [DW-1:0] m7_q [2];
  logic [F:0] u5_q;
  logic [F:0] v5_q, v6_q;
  logic [F:0] w5_q, w6_q, w7_q;
  logic       v5_vld_q, v6_vld_q, v7_vld_q, out_vld_q;
  logic signed [DW-1:0] res;
  logic signed [47:0]   res_wide;
  logic signed [47:0]   res_scaled;
  logic signed [gn3_pkg::NOISE_W-1:0] noise_d;
  logic signed [gn3_pkg::NOISE_W-1:0] noise_q;

  // Corner offsets: the fraction and the fraction minus one.
  assign xs[0] = signed'(DW'(fx_i));
  assign xs[1] = signed'(DW'(fx_i)) - ONE;
  assign ys[0] = signed'(DW'(fy_i));
  assign ys[1] = signed'(DW'(fy_i)) - ONE;
  assign zs[0] = signed'(DW'(fz_i));
  assign zs[1] = signed'(DW'(fz_i)) - ONE;

  // Final blend along z, then scaling to 16 fraction bits.
  assign res        = mix(w7_q, m7_q[0], m7_q[1]);
  assign res_wide   = 48'(res);
  assign res_scaled = (res_wide >>> SHR) <<< SHL;

  // Saturation.
  always_comb begin
    if (res_scaled > 48'(gn3_pkg::NOISE_MAX)) begin
      noise_d = gn3_pkg::NOISE_MAX;
    end else if (res_scaled < 48'(gn3_pkg::NOISE_MIN)) begin
      noise_d = gn3_pkg::NOISE_MIN;
    end else begin
      noise_d = res_scaled[gn3_pkg::NOISE_W-1:0];
    end
  end

  // Data path registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 8; c++) begin
        dot5_q[c] <= gdot(hash_i[c], xs[c % 2], ys[(c / 2) % 2], zs[c / 4]);
      end
      u5_q <= u_i;
      v5_q <= v_i;
      w5_q <= w_i;
      for (int k = 0; k < 4; k++) begin
        l6_q[k] <= mix(u5_q, dot5_q[2*k], dot5_q[2*k+1]);
      end
      v6_q <= v5_q;
      w6_q <= w5_q;
      m7_q[0] <= mix(v6_q, l6_q[0], l6_q[1]);
      m7_q[1] <= mix(v6_q, l6_q[2], l6_q[3]);
      w7_q <= w6_q;
      noise_q <= noise_d;
    end
  end

  // Valid chain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_vld_q  <= 1'b0;
      v6_vld_q  <= 1'b0;
      v7_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      v5_vld_q  <= valid_i;
      v6_vld_q  <= v5_vld_q;
      v7_vld_q  <= v6_vld_q;
      out_vld_q <= v7_vld_q;
    end
  end

  assign valid_o = out_vld_q;
  assign noise_o = noise_q;

endmodule

// ----- hw/rtl/gradient_noise_3d_evaluator_top.sv -----
// Top level of the 3-D gradient noise evaluator.
//
// Input channel (in_valid_i / in_stall_o): a request either loads one byte of
// the permutation table (action 0) or evaluates noise at a point (action 1).
// Output channel (out_valid_o / out_stall_i): one noise value, signed Q1.16,
// for every evaluation request, in request order. Loads give no result.
// The three offset registers are written on the cfg port; the user must do
// so only while idle, as the block itself does not enforce it.
// Throughput: one request per cycle unless stalled. Every pair of table reads
// goes to a copy of its own: the hash chain reads 2, then 4, then 8 entries in
// three stages, so the table is held in seven dual-read copies and loads
// update each copy at its stage, which keeps loads and evaluations in order.
// When the receiver stalls a waiting result, the whole pipeline holds and
// in_stall_o rises until the result is taken.
// Reset clears the valid bits and the offsets; the table is not cleared and
// must be loaded before the first evaluation.
module gradient_noise_3d_evaluator_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                action_i,
  input  logic [7:0]                          table_index_i,
  input  logic [7:0]                          table_value_i,
  input  logic signed [31:0]                  coord_x_i,
  input  logic signed [31:0]                  coord_y_i,
  input  logic signed [31:0]                  coord_z_i,
  input  logic                                cfg_we_i,
  input  logic [gn3_pkg::CFG_IW-1:0]          cfg_index_i,
  input  logic [gn3_pkg::CFG_DW-1:0]          cfg_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [gn3_pkg::NOISE_W-1:0]  noise_value_o
);

  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned AW = gn3_pkg::TBL_AW;
  localparam int unsigned DW = gn3_pkg::TBL_DW;
  localparam int unsigned SW = gn3_pkg::COORD_W + 2;

  logic en;
  logic [gn3_pkg::CFG_DW-1:0] off_x_q, off_y_q, off_z_q;
  logic signed [SW-1:0] sum_x, sum_y, sum_z;

  logic          v1_q, ld1_q, v2_q, ld2_q, v3_q, ld3_q, ev4_q;
  logic [AW-1:0] idx1_q, idx2_q, idx3_q;
  logic [DW-1:0] val1_q, val2_q, val3_q;
  logic [AW-1:0] cx1_q, cy1_q, cz1_q, cy2_q, cz2_q, cz3_q;
  logic [F-1:0]  fx1_q, fy1_q, fz1_q;
  logic [F-1:0]  fx2_q, fy2_q, fz2_q;
  logic [F-1:0]  fx3_q, fy3_q, fz3_q;
  logic [F-1:0]  fx4_q, fy4_q, fz4_q;
  logic [F:0]    fade_u, fade_v, fade_w;

  logic [DW-1:0] pa, pb;
  logic [DW-1:0] paa, pab, pba, pbb;
  logic [AW-1:0] a_addr, b_addr;
  logic [AW-1:0] aa_addr, ab_addr, ba_addr, bb_addr;
  logic [DW-1:0] h_aa0, h_aa1, h_ab0, h_ab1, h_ba0, h_ba1, h_bb0, h_bb1;
  gn3_pkg::hash_t hash [8];

  // The pipeline holds only while a finished result is stalled.
  assign in_stall_o = out_valid_o & out_stall_i;
  assign en         = ~in_stall_o;

  // Offset registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_x_q <= '0;
      off_y_q <= '0;
      off_z_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        gn3_pkg::CFG_OFFSET_X: off_x_q <= cfg_data_i;
        gn3_pkg::CFG_OFFSET_Y: off_y_q <= cfg_data_i;
        gn3_pkg::CFG_OFFSET_Z: off_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Offset sums ahead of the lattice split.
  assign sum_x = SW'(coord_x_i) + signed'(SW'(off_x_q));
  assign sum_y = SW'(coord_y_i) + signed'(SW'(off_y_q));
  assign sum_z = SW'(coord_z_i) + signed'(SW'(off_z_q));

  // Control of the table stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      ev4_q <= 1'b0;
    end else if (en) begin
      v1_q  <= in_valid_i;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      ev4_q <= v3_q & ~ld3_q;
    end
  end

  // Payload of the table stages.
  always_ff @(posedge clk_i) begin
    if (en) begin
      ld1_q  <= (action_i == gn3_pkg::ACT_LOAD);
      idx1_q <= table_index_i;
      val1_q <= table_value_i;
      cx1_q  <= sum_x[F+AW-1:F];
      cy1_q  <= sum_y[F+AW-1:F];
      cz1_q  <= sum_z[F+AW-1:F];
      fx1_q  <= sum_x[F-1:0];
      fy1_q  <= sum_y[F-1:0];
      fz1_q  <= sum_z[F-1:0];
      ld2_q  <= ld1_q;
      idx2_q <= idx1_q;
      val2_q <= val1_q;
      cy2_q  <= cy1_q;
      cz2_q  <= cz1_q;
      fx2_q  <= fx1_q;
      fy2_q  <= fy1_q;
      fz2_q  <= fz1_q;
      ld3_q  <= ld2_q;
      idx3_q <= idx2_q;
      val3_q <= val2_q;
      cz3_q  <= cz2_q;
      fx3_q  <= fx2_q;
      fy3_q  <= fy2_q;
      fz3_q  <= fz2_q;
      fx4_q  <= fx3_q;
      fy4_q  <= fy3_q;
      fz4_q  <= fz3_q;
    end
  end

  // First hash level: p[cx] and p[cx + 1].
  gn3_tbl_ram u_ram1 (
    .clk_i    (clk_i),
    .en_i     (en),
    .we_i     (en & v1_q & ld1_q),
    .waddr_i  (idx1_q),
    .wdata_i  (val1_q),
    .raddr0_i (cx1_q),
    .raddr1_i (cx1_q + AW'(1)),
    .rdata0_o (pa),
    .rdata1_o (pb)
  );

  // Second hash level: rows a and b.
  assign a_addr = pa + cy2_q;
  assign b_addr = pb + cy2_q;

  gn3_tbl_ram u_ram2a (
    .clk_i    (clk_i),
    .en_i     (en),
    .we_i     (en & v2_q & ld2_q),
    .waddr_i  (idx2_q),
    .wdata_i  (val2_q),
    .raddr0_i (a_addr),
    .raddr1_i (a_addr + AW'(1)),
    .rdata0_o (paa),
    .rdata1_o (pab)
  );

  gn3_tbl_ram u_ram2b (
    .clk_i    (clk_i),
    .en_i     (en),
    .we_i     (en & v2_q & ld2_q),
    .waddr_i  (idx2_q),
    .wdata_i  (val2_q),
    .raddr0_i (b_addr),
    .raddr1_i (b_addr + AW'(1)),
    .rdata0_o (pba),
    .rdata1_o (pbb)
  );

  // Third hash level: the eight corner hashes.
  assign aa_addr = paa + cz3_q;
  assign ab_addr = pab + cz3_q;
  assign ba_addr = pba + cz3_q;
  assign bb_addr = pbb + cz3_q;

  gn3_tbl_ram u_ram3a (
    .clk_i    (clk_i),
    .en_i     (en),
    .we_i     (en & v3_q & ld3_q),
    .waddr_i  (idx3_q),
    .wdata_i  (val3_q),
    .raddr0_i (aa_addr),
    .raddr1_i (aa_addr + AW'(1)),
    .rdata0_o (h_aa0),
    .rdata1_o (h_aa1)
  );

  gn3_tbl_ram u_ram3b (
    .clk_i    (clk_i),
    .en_i     (en),
    .we_i     (en & v3_q & ld3_q),
    .waddr_i  (idx3_q),
    .wdata_i  (val3_q),
    .raddr0_i (ab_addr),
    .raddr1_i (ab_addr + AW'(1)),
    .rdata0_o (h_ab0),
    .rdata1_o (h_ab1)
  );

  gn3_tbl_ram u_ram3c (
    .clk_i    (clk_i),
    .en_i     (en),
    .we_i     (en & v3_q & ld3_q),
    .waddr_i  (idx3_q),
    .wdata_i  (val3_q),
    .raddr0_i (ba_addr),
    .raddr1_i (ba_addr + AW'(1)),
    .rdata0_o (h_ba0),
    .rdata1_o (h_ba1)
  );

  gn3_tbl_ram u_ram3d (
    .clk_i    (clk_i),
    .en_i     (en),
    .we_i     (en & v3_q & ld3_q),
    .waddr_i  (idx3_q),
    .wdata_i  (val3_q),
    .raddr0_i (bb_addr),
    .raddr1_i (bb_addr + AW'(1)),
    .rdata0_o (h_bb0),
    .rdata1_o (h_bb1)
  );

  // Corner order: bit 0 selects x + 1, bit 1 y + 1, bit 2 z + 1.
  assign hash[0] = h_aa0[3:0];
  assign hash[1] = h_ba0[3:0];
  assign hash[2] = h_ab0[3:0];
  assign hash[3] = h_bb0[3:0];
  assign hash[4] = h_aa1[3:0];
  assign hash[5] = h_ba1[3:0];
  assign hash[6] = h_ab1[3:0];
  assign hash[7] = h_bb1[3:0];

  // Fade weights, aligned with the corner hashes.
  gn3_fade #(.FRAC_BITS(F)) u_fade_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .frac_i (fx1_q),
    .fade_o (fade_u)
  );

  gn3_fade #(.FRAC_BITS(F)) u_fade_y (
    .clk_i  (clk_i),
    .en_i   (en),
    .frac_i (fy1_q),
    .fade_o (fade_v)
  );

  gn3_fade #(.FRAC_BITS(F)) u_fade_z (
    .clk_i  (clk_i),
    .en_i   (en),
    .frac_i (fz1_q),
    .fade_o (fade_w)
  );

  // Gradients, blend and output register.
  gn3_blend #(.FRAC_BITS(F)) u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ev4_q),
    .hash_i  (hash),
    .fx_i    (fx4_q),
    .fy_i    (fy4_q),
    .fz_i    (fz4_q),
    .u_i     (fade_u),
    .v_i     (fade_v),
    .w_i     (fade_w),
    .valid_o (out_valid_o),
    .noise_o (noise_value_o)
  );

endmodule

// ----- tb/gn3_checker.sv -----
// Checker for the 3-D gradient noise evaluator: predicts and compares results.
`timescale 1ns / 1ps
module gn3_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  logic                               action_i,
  input  logic [7:0]                         table_index_i,
  input  logic [7:0]                         table_value_i,
  input  logic signed [31:0]                 coord_x_i,
  input  logic signed [31:0]                 coord_y_i,
  input  logic signed [31:0]                 coord_z_i,
  input  logic                               cfg_we_i,
  input  logic [gn3_pkg::CFG_IW-1:0]         cfg_index_i,
  input  logic [gn3_pkg::CFG_DW-1:0]         cfg_data_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  logic signed [gn3_pkg::NOISE_W-1:0] noise_value_i,
  output int                                 fail_count_o,
  output int                                 pending_o
);

  localparam int FB = 16;
  localparam longint ONE = 64'sd1 <<< FB;

  logic [7:0] perm_q [256];
  longint unsigned ofs_x_q, ofs_y_q, ofs_z_q;
  logic signed [gn3_pkg::NOISE_W-1:0] noise_fifo [$];

  assign pending_o = noise_fifo.size();

  function automatic longint floor_shr(longint v);
    return v >>> FB;
  endfunction

  function automatic longint fade_w(longint f);
    longint sq, cube, p;
    sq = floor_shr(f * f);
    cube = floor_shr(sq * f);
    p = 6 * sq - 15 * f + 10 * ONE;
    return floor_shr(cube * p);
  endfunction

  function automatic longint blend(longint t, longint a, longint b);
    return a + floor_shr(t * (b - a));
  endfunction

  function automatic longint grad_dot(logic [7:0] hv, longint x, longint y, longint z);
    logic [3:0] h;
    longint u, v;
    h = hv[3:0];
    u = (h < 8) ? x : y;
    v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic logic [7:0] perm_at(longint i);
    return perm_q[i[7:0]];
  endfunction

  // Full noise evaluation at a point already offset, then saturation.
  function automatic logic signed [gn3_pkg::NOISE_W-1:0] noise_at(longint px, longint py,
                                                                  longint pz);
    longint cx, cy, cz, x, y, z, u, v, w, x1, y1, z1;
    longint a, aa, ab, b, ba, bb, l0, l1, l2, l3, n;
    cx = (px >>> FB) & 255; x = px & (ONE - 1);
    cy = (py >>> FB) & 255; y = py & (ONE - 1);
    cz = (pz >>> FB) & 255; z = pz & (ONE - 1);
    u = fade_w(x); v = fade_w(y); w = fade_w(z);
    x1 = x - ONE; y1 = y - ONE; z1 = z - ONE;
    a  = perm_at(cx) + cy;
    aa = perm_at(a) + cz;
    ab = perm_at(a + 1) + cz;
    b  = perm_at(cx + 1) + cy;
    ba = perm_at(b) + cz;
    bb = perm_at(b + 1) + cz;
    l0 = blend(u, grad_dot(perm_at(aa), x, y, z), grad_dot(perm_at(ba), x1, y, z));
    l1 = blend(u, grad_dot(perm_at(ab), x, y1, z), grad_dot(perm_at(bb), x1, y1, z));
    l2 = blend(u, grad_dot(perm_at(aa + 1), x, y, z1),
               grad_dot(perm_at(ba + 1), x1, y, z1));
    l3 = blend(u, grad_dot(perm_at(ab + 1), x, y1, z1),
               grad_dot(perm_at(bb + 1), x1, y1, z1));
    n = blend(w, blend(v, l0, l1), blend(v, l2, l3));
    if (n > 131071) n = 131071;
    if (n < -131072) n = -131072;
    return n[gn3_pkg::NOISE_W-1:0];
  endfunction

  // Track configuration, predict on accepted requests, compare on results.
  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [gn3_pkg::NOISE_W-1:0] exp_v;
    if (!rst_ni) begin
      ofs_x_q <= 0;
      ofs_y_q <= 0;
      ofs_z_q <= 0;
      fail_count_o <= 0;
      noise_fifo.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          gn3_pkg::CFG_OFFSET_X: ofs_x_q <= 64'(cfg_data_i);
          gn3_pkg::CFG_OFFSET_Y: ofs_y_q <= 64'(cfg_data_i);
          gn3_pkg::CFG_OFFSET_Z: ofs_z_q <= 64'(cfg_data_i);
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (action_i == gn3_pkg::ACT_LOAD) begin
          perm_q[table_index_i] = table_value_i;
        end else begin
          noise_fifo.push_back(noise_at(longint'(coord_x_i) + longint'(ofs_x_q),
                                        longint'(coord_y_i) + longint'(ofs_y_q),
                                        longint'(coord_z_i) + longint'(ofs_z_q)));
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (noise_fifo.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d", $time,
                   noise_value_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_v = noise_fifo.pop_front();
          if (exp_v !== noise_value_i) begin
            $display("%0t: noise_value mismatch, expected %0d, actual %0d", $time,
                     exp_v, noise_value_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

// ----- tb/tb_top.sv -----
// Testbench top: drives requests and configuration, and gives the verdict.
`timescale 1ns / 1ps
module tb_top;

  logic clk, rst_n;
  logic in_valid, in_stall, action;
  logic [7:0] t_index, t_value;
  logic signed [31:0] cx, cy, cz;
  logic cfg_we;
  logic [gn3_pkg::CFG_IW-1:0] cfg_index;
  logic [gn3_pkg::CFG_DW-1:0] cfg_data;
  logic out_valid, out_stall;
  logic signed [gn3_pkg::NOISE_W-1:0] noise;
  int fails, pending;
  int send_idle_pct, recv_idle_pct;
  longint cycles;

  gradient_noise_3d_evaluator_top DUT (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .action_i(action), .table_index_i(t_index), .table_value_i(t_value),
    .coord_x_i(cx), .coord_y_i(cy), .coord_z_i(cz), .cfg_we_i(cfg_we),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data), .out_valid_o(out_valid),
    .out_stall_i(out_stall), .noise_value_o(noise)
  );

  gn3_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_stall_i(in_stall),
    .action_i(action), .table_index_i(t_index), .table_value_i(t_value),
    .coord_x_i(cx), .coord_y_i(cy), .coord_z_i(cz), .cfg_we_i(cfg_we),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data), .out_valid_i(out_valid),
    .out_stall_i(out_stall), .noise_value_i(noise), .fail_count_o(fails),
    .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver stalls at random; a watchdog bounds the run.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Send one request, idling before it at random.
  task automatic send_req(logic act, logic [7:0] idx, logic [7:0] val,
                          logic [31:0] x, logic [31:0] y, logic [31:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    t_index <= idx;
    t_value <= val;
    cx <= x;
    cy <= y;
    cz <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_offsets(logic [23:0] ox, logic [23:0] oy, logic [23:0] oz);
    cfg_we <= 1'b1;
    cfg_index <= gn3_pkg::CFG_OFFSET_X; cfg_data <= ox; @(posedge clk);
    cfg_index <= gn3_pkg::CFG_OFFSET_Y; cfg_data <= oy; @(posedge clk);
    cfg_index <= gn3_pkg::CFG_OFFSET_Z; cfg_data <= oz; @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic eval_rand();
    logic [31:0] x, y, z;
    x = $urandom(); y = $urandom(); z = $urandom();
    // Mostly small coordinates, sometimes the full range.
    if ($urandom_range(3) != 0) begin
      x = $signed(x) >>> 12; y = $signed(y) >>> 12; z = $signed(z) >>> 12;
    end
    send_req(gn3_pkg::ACT_EVAL, 8'($urandom()), 8'($urandom()), x, y, z);
  endtask

  initial begin
    logic [7:0] i8;
    logic [23:0] ofs_set [4];
    rst_n = 1'b0;
    in_valid = 1'b0; action = gn3_pkg::ACT_LOAD; t_index = 0; t_value = 0;
    cx = 0; cy = 0; cz = 0; cfg_we = 1'b0; cfg_index = gn3_pkg::CFG_OFFSET_X;
    cfg_data = 0;
    out_stall = 1'b0; cycles = 0;
    send_idle_pct = 22; recv_idle_pct = 65;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the whole table before any evaluation reads it.
    for (int k = 0; k < 256; k++) begin
      i8 = 8'(k);
      send_req(gn3_pkg::ACT_LOAD, i8, i8 * 8'd151 + 8'd7, $urandom(), $urandom(),
               $urandom());
    end

    // Directed points: coordinate extremes, lattice points, negative values.
    send_req(gn3_pkg::ACT_EVAL, 8'hff, 8'hff, 0, 0, 0);
    send_req(gn3_pkg::ACT_EVAL, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_req(gn3_pkg::ACT_EVAL, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000);
    send_req(gn3_pkg::ACT_EVAL, 0, 0, 32'hffffffff, 32'h00008000, 32'hffff0000);
    send_req(gn3_pkg::ACT_EVAL, 0, 0, 32'h00010000, 32'h0000ffff, 32'h00ff8000);
    send_req(gn3_pkg::ACT_EVAL, 0, 0, 32'hfffe8000, 32'h7fff0000, 32'h0001c000);
    send_req(gn3_pkg::ACT_EVAL, 0, 0, 32'h00004000, 32'h00004000, 32'h00004000);
    // Entries 0 to 7 set to zero: every corner hash of the origin cell is the same.
    for (int k = 0; k < 8; k++) send_req(gn3_pkg::ACT_LOAD, 8'(k), 8'h00, 0, 0, 0);
    send_req(gn3_pkg::ACT_EVAL, 0, 0, 32'h00008000, 32'h00008000, 32'h00008000);
    send_req(gn3_pkg::ACT_EVAL, 0, 0, 32'h0000fff0, 32'h0000fff0, 32'h0000fff0);
    send_req(gn3_pkg::ACT_LOAD, 8'hff, 8'hff, 0, 0, 0);
    drain();

    ofs_set[0] = 24'hffffff;
    ofs_set[1] = 24'h000000;
    ofs_set[2] = 24'h800000;
    ofs_set[3] = 24'h123456;
    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 1) begin
        send_idle_pct = 65; recv_idle_pct = 22;
      end else if (ph >= 2) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      set_offsets(ofs_set[ph], 24'($urandom()), ofs_set[(ph + 1) % 4]);
      for (int n = 0; n < 160; n++) begin
        if ($urandom_range(9) == 0)
          send_req(gn3_pkg::ACT_LOAD, 8'($urandom()), 8'($urandom()), $urandom(),
                   $urandom(), $urandom());
        else
          eval_rand();
        // Pause until all results are in, once per phase.
        if (n == 80) drain();
      end
      drain();
    end

    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ----- gradient_noise_3d_evaluator_top.f -----
hw/rtl/gn3_pkg.sv
hw/rtl/gn3_tbl_ram.sv
hw/rtl/gn3_fade.sv
hw/rtl/gn3_blend.sv
hw/rtl/gradient_noise_3d_evaluator_top.sv
tb/gn3_checker.sv
tb/tb_top.sv
